// File: src/marching_squares_cell_points_core_defines.svh
// assertion macros shared by the cell point core
// expects clk and rst in the scope of the module that uses them
`ifndef MARCHING_SQUARES_CELL_POINTS_CORE_DEFINES_SVH
`define MARCHING_SQUARES_CELL_POINTS_CORE_DEFINES_SVH

// same-cycle implication
`define MSCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mscp_pkg.sv
// shared types and constants for the marching squares cell point core
// no dependencies
`timescale 1ns / 1ps

package mscp_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W = 3;

  // bookkeeping that travels with each point through the pipe
  typedef struct packed {
    logic [2:0] index;
    logic       last;
    logic       empty;
  } point_meta_t;

endpackage

// File: src/marching_squares_cell_points_core.sv
// path: cell register, issue register, product stage, divide stages, output register
// a cell yields at most 8 point words (one empty word if it has none); one point leaves the issue stage
// per cycle and the divide pipe takes a new point every cycle while the output is not stalled
// reset: synchronous, clears fill mode, all valid bits and the issue sequencer
// depends on mscp_pkg, mscp_cross_pipe and the defines header
`timescale 1ns / 1ps
`include "marching_squares_cell_points_core_defines.svh"

module marching_squares_cell_points_core import mscp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          fill_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] val_00,
  input  logic signed [VALUE_WIDTH-1:0] val_10,
  input  logic signed [VALUE_WIDTH-1:0] val_11,
  input  logic signed [VALUE_WIDTH-1:0] val_01,
  input  logic signed [VALUE_WIDTH-1:0] x_00,
  input  logic signed [VALUE_WIDTH-1:0] y_00,
  input  logic signed [VALUE_WIDTH-1:0] x_10,
  input  logic signed [VALUE_WIDTH-1:0] y_10,
  input  logic signed [VALUE_WIDTH-1:0] x_11,
  input  logic signed [VALUE_WIDTH-1:0] y_11,
  input  logic signed [VALUE_WIDTH-1:0] x_01,
  input  logic signed [VALUE_WIDTH-1:0] y_01,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] point_x,
  output logic signed [VALUE_WIDTH-1:0] point_y,
  output logic [2:0]                    point_index,
  output logic                          last_point,
  output logic                          no_points
);

  localparam int W = VALUE_WIDTH;
  localparam int META_W = $bits(point_meta_t);
  localparam int TAG_W = 2 + 2 * W + META_W;

  logic fill_reg;
  logic en;

  // cell register and issue sequencer
  logic                 busy, empty_cell;
  logic [NUM_SLOTS-1:0] pending, rest, mask_in;
  logic [2:0]           idx;
  logic [W-1:0]         v0r, v1r, v2r, v3r;
  logic [W-1:0]         x0r, x1r, x2r, x3r, y0r, y1r, y2r, y3r;
  logic [W-1:0]         vin [4];
  logic                 in_fire, issue_fire, done_now;

  logic [SLOT_W-1:0] slot;
  logic [1:0]        edge_a;
  logic [W-1:0]      e_v0, e_v1, e_x0, e_x1, e_y0, e_y1;
  logic [W:0]        d_full, dx_full, dy_full, d_neg, dx_neg, dy_neg;
  logic [W-1:0]      a_mag;
  logic              is_cross;
  point_meta_t       meta_now;

  // issue register feeding the multiplier
  logic             iss_valid;
  logic [W-1:0]     iss_a, iss_bx, iss_by, iss_den;
  logic [TAG_W-1:0] iss_tag;

  logic             pipe_valid;
  logic [W-1:0]     pipe_qx, pipe_qy;
  logic [TAG_W-1:0] pipe_tag;
  logic             t_negx, t_negy;
  logic [W-1:0]     t_p0x, t_p0y;
  point_meta_t      t_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_reg <= 1'b0;
    end else if (cfg_valid) begin
      fill_reg <= fill_mode;
    end
  end

  assign en = !out_valid || out_ready;

  assign vin[0] = val_00;
  assign vin[1] = val_10;
  assign vin[2] = val_11;
  assign vin[3] = val_01;

  // even slot: corner of an edge, odd slot: crossing on that edge
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mask_in[2*i]   = fill_reg && (vin[i][W-1] || vin[i] == '0);
      mask_in[2*i+1] = vin[i][W-1] != vin[(i+1)%4][W-1];
    end
  end

  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) slot = SLOT_W'(i);
    end
  end

  assign rest       = pending & ~(NUM_SLOTS'(1) << slot);
  assign issue_fire = busy && en;
  assign done_now   = issue_fire && (empty_cell || rest == '0);
  assign in_ready   = !busy || done_now;
  assign in_fire    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pending    <= '0;
      idx        <= '0;
      empty_cell <= 1'b0;
    end else if (in_fire) begin
      busy       <= 1'b1;
      pending    <= mask_in;
      idx        <= '0;
      empty_cell <= mask_in == '0;
    end else if (done_now) begin
      busy <= 1'b0;
    end else if (issue_fire) begin
      pending <= rest;
      idx     <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v0r <= val_00; v1r <= val_10; v2r <= val_11; v3r <= val_01;
      x0r <= x_00;   x1r <= x_10;   x2r <= x_11;   x3r <= x_01;
      y0r <= y_00;   y1r <= y_10;   y2r <= y_11;   y3r <= y_01;
    end
  end

  assign edge_a = slot[SLOT_W-1:1];

  always_comb begin
    case (edge_a)
      2'd0: begin
        e_v0 = v0r; e_v1 = v1r; e_x0 = x0r; e_x1 = x1r; e_y0 = y0r; e_y1 = y1r;
      end
      2'd1: begin
        e_v0 = v1r; e_v1 = v2r; e_x0 = x1r; e_x1 = x2r; e_y0 = y1r; e_y1 = y2r;
      end
      2'd2: begin
        e_v0 = v2r; e_v1 = v3r; e_x0 = x2r; e_x1 = x3r; e_y0 = y2r; e_y1 = y3r;
      end
      default: begin
        e_v0 = v3r; e_v1 = v0r; e_x0 = x3r; e_x1 = x0r; e_y0 = y3r; e_y1 = y0r;
      end
    endcase
  end

  assign d_full  = {e_v0[W-1], e_v0} - {e_v1[W-1], e_v1};
  assign dx_full = {e_x1[W-1], e_x1} - {e_x0[W-1], e_x0};
  assign dy_full = {e_y1[W-1], e_y1} - {e_y0[W-1], e_y0};
  assign d_neg   = -d_full;
  assign dx_neg  = -dx_full;
  assign dy_neg  = -dy_full;
  assign a_mag   = e_v0[W-1] ? -e_v0 : e_v0;
  assign is_cross = slot[0] && !empty_cell;

  always_comb begin
    meta_now.index = idx;
    meta_now.last  = empty_cell || rest == '0;
    meta_now.empty = empty_cell;
  end

  // corners and the empty word go through with a zero numerator and unit divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else if (en) begin
      iss_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iss_a   <= is_cross ? a_mag : '0;
      iss_bx  <= dx_full[W] ? dx_neg[W-1:0] : dx_full[W-1:0];
      iss_by  <= dy_full[W] ? dy_neg[W-1:0] : dy_full[W-1:0];
      iss_den <= is_cross ? (d_full[W] ? d_neg[W-1:0] : d_full[W-1:0]) : W'(1);
      iss_tag <= {e_v0[W-1] ^ dx_full[W] ^ d_full[W],
                  e_v0[W-1] ^ dy_full[W] ^ d_full[W],
                  empty_cell ? {W{1'b0}} : e_x0,
                  empty_cell ? {W{1'b0}} : e_y0,
                  meta_now};
    end
  end

  mscp_cross_pipe #(
    .W     (W),
    .TAG_W (TAG_W)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (iss_valid),
    .a         (iss_a),
    .bx        (iss_bx),
    .by        (iss_by),
    .den       (iss_den),
    .tag_in    (iss_tag),
    .out_valid (pipe_valid),
    .qx        (pipe_qx),
    .qy        (pipe_qy),
    .tag_out   (pipe_tag)
  );

  assign {t_negx, t_negy, t_p0x, t_p0y, t_meta} = pipe_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_x     <= t_negx ? t_p0x - pipe_qx : t_p0x + pipe_qx;
      point_y     <= t_negy ? t_p0y - pipe_qy : t_p0y + pipe_qy;
      point_index <= t_meta.index;
      last_point  <= t_meta.last;
      no_points   <= t_meta.empty;
    end
  end

  `MSCP_ASSERT_NOW(a_empty_word, out_valid && no_points, last_point && point_index == 3'd0 && point_x == '0 && point_y == '0, "empty cell word malformed")
  `MSCP_ASSERT_NOW(a_pending_live, busy && !empty_cell, pending != '0, "live cell with nothing left to issue")
  `MSCP_ASSERT_NOW(a_bypass_zero, pipe_valid && t_meta.empty, pipe_qx == '0 && pipe_qy == '0, "empty word picked up an offset")
  `MSCP_ASSERT_NXT(a_stall_hold, busy && !en, busy && $stable(pending) && $stable(idx), "sequencer moved during stall")

endmodule

// File: src/mscp_cross_pipe.sv
// pipelined crossing unit: one product stage, then one restoring divide bit per stage
// two lanes (x and y) share the divisor; depends on mscp_pkg
`timescale 1ns / 1ps

module mscp_cross_pipe import mscp_pkg::*; #(
  parameter int W = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     bx,
  input  logic [W-1:0]     by,
  input  logic [W-1:0]     den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [W-1:0]     qx,
  output logic [W-1:0]     qy,
  output logic [TAG_W-1:0] tag_out
);

  logic             vld  [0:W];
  logic [W-1:0]     remx [0:W];
  logic [W-1:0]     remy [0:W];
  logic [W-1:0]     nqx  [0:W];
  logic [W-1:0]     nqy  [0:W];
  logic [W-1:0]     dreg [0:W];
  logic [TAG_W-1:0] tags [0:W];

  logic [2*W-1:0] prodx, prody;

  assign prodx = {{W{1'b0}}, a} * {{W{1'b0}}, bx};
  assign prody = {{W{1'b0}}, a} * {{W{1'b0}}, by};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // quotient fits in W bits, so the high half is already below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      remx[0] <= prodx[2*W-1:W];
      nqx[0]  <= prodx[W-1:0];
      remy[0] <= prody[2*W-1:W];
      nqy[0]  <= prody[W-1:0];
      dreg[0] <= den;
      tags[0] <= tag_in;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] tx, ty, sx, sy;
    logic       gex, gey;

    assign tx  = {remx[k], nqx[k][W-1]};
    assign ty  = {remy[k], nqy[k][W-1]};
    assign gex = tx >= {1'b0, dreg[k]};
    assign gey = ty >= {1'b0, dreg[k]};
    assign sx  = tx - {1'b0, dreg[k]};
    assign sy  = ty - {1'b0, dreg[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx[k+1] <= gex ? sx[W-1:0] : tx[W-1:0];
        remy[k+1] <= gey ? sy[W-1:0] : ty[W-1:0];
        nqx[k+1]  <= {nqx[k][W-2:0], gex};
        nqy[k+1]  <= {nqy[k][W-2:0], gey};
        dreg[k+1] <= dreg[k];
        tags[k+1] <= tags[k];
      end
    end
  end

  assign out_valid = vld[W];
  assign qx        = nqx[W];
  assign qy        = nqy[W];
  assign tag_out   = tags[W];

endmodule
